[rtl/core/mlp_pkg.sv]
`timescale 1ns / 1ps

package mlp_pkg;

   localparam int NUM_CTL    = 13;
   localparam int NUM_WRITES = 23;
   localparam int CTL_W      = 4;
   localparam int STEP_W     = $clog2(NUM_WRITES);
   localparam int BYTE_W     = 8;

   // Command codes
   localparam logic CMD_SET     = 1'b0;
   localparam logic CMD_RESTORE = 1'b1;

   // Side codes
   localparam logic [1:0] SIDE_BOTH  = 2'd0;
   localparam logic [1:0] SIDE_LEFT  = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;

   // Control indexes
   localparam logic [CTL_W-1:0] CTL_MASTER  = 4'd0;
   localparam logic [CTL_W-1:0] CTL_OGAIN   = 4'd1;
   localparam logic [CTL_W-1:0] CTL_IGAIN   = 4'd2;
   localparam logic [CTL_W-1:0] CTL_TREB    = 4'd3;
   localparam logic [CTL_W-1:0] CTL_BASS    = 4'd4;
   localparam logic [CTL_W-1:0] CTL_PCM     = 4'd5;
   localparam logic [CTL_W-1:0] CTL_SYNTH   = 4'd6;
   localparam logic [CTL_W-1:0] CTL_CD      = 4'd7;
   localparam logic [CTL_W-1:0] CTL_LINE    = 4'd8;
   localparam logic [CTL_W-1:0] CTL_MIC     = 4'd9;
   localparam logic [CTL_W-1:0] CTL_SPEAKER = 4'd10;
   localparam logic [CTL_W-1:0] CTL_OSWITCH = 4'd11;
   localparam logic [CTL_W-1:0] CTL_ISWITCH = 4'd12;

   // Level mapping constants
   localparam logic [7:0]  LEVEL_MAX   = 8'd100;
   localparam logic [7:0]  THRESH_BASE = 8'd155;
   localparam logic [7:0]  TONE_BASE   = 8'd78;
   // floor(c*255/100) == (c*SCALE_MUL) >> SCALE_SHIFT for c in 0..100
   localparam logic [13:0] SCALE_MUL   = 14'd10445;
   localparam int          SCALE_SHIFT = 12;

   typedef enum logic [1:0] {
      MAP_SCALED = 2'd0,
      MAP_THRESH = 2'd1,
      MAP_TONE   = 2'd2,
      MAP_SWITCH = 2'd3
   } map_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_RUN  = 1'b1
   } seq_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] addr;
      logic [CTL_W-1:0]  ctl;
      logic              right;
      map_type           map;
   } write_desc_type;

   typedef struct packed {
      logic              wr;
      logic              restore;
      logic [CTL_W-1:0]  ctl;
      logic [1:0]        side;
      logic [BYTE_W-1:0] level;
   } lvl_update_type;

   typedef struct packed {
      logic              load;
      logic              last;
      logic [BYTE_W-1:0] addr;
      logic [CTL_W-1:0]  ctl;
      logic              right;
      map_type           map;
   } seq_step_type;

   function automatic logic [BYTE_W-1:0] dflt_left(input logic [CTL_W-1:0] ctl);
      logic [BYTE_W-1:0] v;
      unique case (ctl)
         CTL_MASTER, CTL_TREB, CTL_BASS: v = 8'd50;
         CTL_PCM, CTL_SYNTH:             v = 8'd90;
         CTL_CD:                         v = 8'd81;
         CTL_LINE:                       v = 8'd65;
         CTL_OSWITCH:                    v = 8'd31;
         CTL_ISWITCH:                    v = 8'd85;
         default:                        v = 8'd0;
      endcase
      return v;
   endfunction

   function automatic logic [BYTE_W-1:0] dflt_right(input logic [CTL_W-1:0] ctl);
      logic [BYTE_W-1:0] v;
      if (ctl == CTL_ISWITCH) v = 8'd43;
      else                    v = dflt_left(ctl);
      return v;
   endfunction

   function automatic logic is_mono(input logic [CTL_W-1:0] ctl);
      return (ctl == CTL_MIC) || (ctl == CTL_SPEAKER) || (ctl == CTL_OSWITCH);
   endfunction

   function automatic write_desc_type run_entry(input logic [STEP_W-1:0] k);
      write_desc_type d;
      unique case (k)
         5'd0:    d = '{8'h30, CTL_MASTER,  1'b0, MAP_SCALED};
         5'd1:    d = '{8'h31, CTL_MASTER,  1'b1, MAP_SCALED};
         5'd2:    d = '{8'h32, CTL_PCM,     1'b0, MAP_THRESH};
         5'd3:    d = '{8'h33, CTL_PCM,     1'b1, MAP_THRESH};
         5'd4:    d = '{8'h34, CTL_SYNTH,   1'b0, MAP_THRESH};
         5'd5:    d = '{8'h35, CTL_SYNTH,   1'b1, MAP_THRESH};
         5'd6:    d = '{8'h36, CTL_CD,      1'b0, MAP_THRESH};
         5'd7:    d = '{8'h37, CTL_CD,      1'b1, MAP_THRESH};
         5'd8:    d = '{8'h38, CTL_LINE,    1'b0, MAP_THRESH};
         5'd9:    d = '{8'h39, CTL_LINE,    1'b1, MAP_THRESH};
         5'd10:   d = '{8'h3a, CTL_MIC,     1'b0, MAP_THRESH};
         5'd11:   d = '{8'h3b, CTL_SPEAKER, 1'b0, MAP_THRESH};
         5'd12:   d = '{8'h3f, CTL_IGAIN,   1'b0, MAP_SCALED};
         5'd13:   d = '{8'h40, CTL_IGAIN,   1'b1, MAP_SCALED};
         5'd14:   d = '{8'h41, CTL_OGAIN,   1'b0, MAP_SCALED};
         5'd15:   d = '{8'h42, CTL_OGAIN,   1'b1, MAP_SCALED};
         5'd16:   d = '{8'h44, CTL_TREB,    1'b0, MAP_TONE};
         5'd17:   d = '{8'h45, CTL_TREB,    1'b1, MAP_TONE};
         5'd18:   d = '{8'h46, CTL_BASS,    1'b0, MAP_TONE};
         5'd19:   d = '{8'h47, CTL_BASS,    1'b1, MAP_TONE};
         5'd20:   d = '{8'h3c, CTL_OSWITCH, 1'b0, MAP_SWITCH};
         5'd21:   d = '{8'h3d, CTL_ISWITCH, 1'b0, MAP_SWITCH};
         5'd22:   d = '{8'h3e, CTL_ISWITCH, 1'b1, MAP_SWITCH};
         default: d = '{8'h30, CTL_MASTER,  1'b0, MAP_SCALED};
      endcase
      return d;
   endfunction

endpackage

[rtl/core/mixer_level_programmer.sv]
`timescale 1ns / 1ps

// Mixer level programmer: holds left/right levels of 13 mixer controls and,
// for every request transaction, emits the full run of 23 mixer register
// writes in a fixed order.
// Request channel (req_*): cmd selects set-one-level or restore-defaults;
// control, side and level describe the set. Mono controls keep left only.
// Response channel (rsp_*): one transaction per register write, carrying
// mixer_addr, mixer_data and last (high on the 23rd write of the run).
// The first write is loaded into the output register after the sequencer has
// entered its run state, once the output register is free. Throughput: one
// write per cycle when rsp_ready stays high; the next request is taken once
// the sequencer has issued its 23rd write into the output register.
// The rate is set by the sequencer, which advances one table step for each
// write it loads; the single mapping unit maps every step combinationally.
// Reset loads the default level table and leaves the output register empty.
// When the receiver stalls, the output register holds its write and the
// sequencer waits; nothing is dropped.
module mixer_level_programmer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [mlp_pkg::CTL_W-1:0]      req_control,
   input  logic [1:0]                     req_side,
   input  logic [mlp_pkg::BYTE_W-1:0]     req_level,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mlp_pkg::BYTE_W-1:0]     rsp_mixer_addr,
   output logic [mlp_pkg::BYTE_W-1:0]     rsp_mixer_data,
   output logic                           rsp_last
);
   import mlp_pkg::*;

   lvl_update_type    upd;
   seq_step_type      step;
   logic              seq_idle;
   logic              req_take;
   logic              slot_free;
   logic [BYTE_W-1:0] rd_level;
   logic [BYTE_W-1:0] map_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   // Accept a request only while the sequencer is idle.
   assign req_ready = seq_idle;
   assign req_take  = req_valid && req_ready;

   // Apply the level update at the accept edge; the run reads the new table.
   assign upd.wr      = req_take;
   assign upd.restore = (req_cmd == CMD_RESTORE);
   assign upd.ctl     = req_control;
   assign upd.side    = req_side;
   assign upd.level   = req_level;

   // The output register is free when empty or being drained this cycle.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   mlp_level_store u_store (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .rd_ctl   (step.ctl),
      .rd_right (step.right),
      .rd_level (rd_level)
   );

   mlp_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .slot_free (slot_free),
      .idle      (seq_idle),
      .step      (step)
   );

   mlp_map_unit u_map (
      .level (rd_level),
      .map   (step.map),
      .data  (map_data)
   );

   // Output register: load a new write on a sequencer step, drop on handoff.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (step.load) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = step.addr;
         rsp_data_in  = map_data;
         rsp_last_in  = step.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mixer_addr = rsp_addr_ff;
   assign rsp_mixer_data = rsp_data_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

[rtl/core/mlp_level_store.sv]
`timescale 1ns / 1ps

module mlp_level_store (
   input  logic                          clock,
   input  logic                          reset,
   input  mlp_pkg::lvl_update_type       upd,
   input  logic [mlp_pkg::CTL_W-1:0]     rd_ctl,
   input  logic                          rd_right,
   output logic [mlp_pkg::BYTE_W-1:0]    rd_level
);
   import mlp_pkg::*;

   logic [BYTE_W-1:0] left_ff  [NUM_CTL];
   logic [BYTE_W-1:0] right_ff [NUM_CTL];
   logic [BYTE_W-1:0] left_in  [NUM_CTL];
   logic [BYTE_W-1:0] right_in [NUM_CTL];

   always_comb begin
      for (int i = 0; i < NUM_CTL; i++) begin
         left_in[i]  = left_ff[i];
         right_in[i] = right_ff[i];
         if (upd.wr && upd.restore) begin
            left_in[i]  = dflt_left(CTL_W'(i));
            right_in[i] = dflt_right(CTL_W'(i));
         end else if (upd.wr && upd.ctl == CTL_W'(i)) begin
            if (is_mono(CTL_W'(i)) || upd.side != SIDE_RIGHT) left_in[i] = upd.level;
            if (!is_mono(CTL_W'(i)) && upd.side != SIDE_LEFT) right_in[i] = upd.level;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CTL; i++) begin
         if (reset) begin
            left_ff[i]  <= dflt_left(CTL_W'(i));
            right_ff[i] <= dflt_right(CTL_W'(i));
         end else begin
            left_ff[i]  <= left_in[i];
            right_ff[i] <= right_in[i];
         end
      end
   end

   // rd_ctl always comes from the run table, so it stays below NUM_CTL
   assign rd_level = rd_right ? right_ff[rd_ctl] : left_ff[rd_ctl];

endmodule

[rtl/core/mlp_map_unit.sv]
`timescale 1ns / 1ps

module mlp_map_unit (
   input  logic [mlp_pkg::BYTE_W-1:0] level,
   input  mlp_pkg::map_type           map,
   output logic [mlp_pkg::BYTE_W-1:0] data
);
   import mlp_pkg::*;

   logic [6:0]  clamped;
   logic [20:0] prod;

   assign clamped = (level > LEVEL_MAX) ? LEVEL_MAX[6:0] : level[6:0];
   assign prod    = 21'(clamped) * 21'(SCALE_MUL);

   always_comb begin
      case (map)
         MAP_SCALED: data = prod[SCALE_SHIFT +: BYTE_W];
         MAP_THRESH: data = (level == '0) ? '0 : THRESH_BASE + BYTE_W'(clamped);
         MAP_TONE:   data = TONE_BASE + BYTE_W'(clamped);
         default:    data = level;
      endcase
   end

endmodule

[rtl/core/mlp_sequencer.sv]
`timescale 1ns / 1ps

module mlp_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  slot_free,
   output logic                  idle,
   output mlp_pkg::seq_step_type step
);
   import mlp_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] k_ff, k_in;
   write_desc_type    desc;
   logic              at_last;
   logic              load;

   assign desc    = run_entry(k_ff);
   assign at_last = (k_ff == STEP_W'(NUM_WRITES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (start) state_in = SEQ_RUN;
         SEQ_RUN:  if (slot_free && at_last) state_in = SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      idle = 1'b0;
      load = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: idle = 1'b1;
         SEQ_RUN:  load = slot_free;
         default:  idle = 1'b0;
      endcase
   end

   always_comb begin
      k_in = k_ff;
      if (start && idle)  k_in = '0;
      else if (load)      k_in = k_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   assign step.load  = load;
   assign step.last  = at_last;
   assign step.addr  = desc.addr;
   assign step.ctl   = desc.ctl;
   assign step.right = desc.right;
   assign step.map   = desc.map;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import mlp_pkg::*;

   // Give up once this many cycles pass with no transaction on either channel.
   localparam int STALL_LIMIT = 2000;
   // Cycles to keep watching the response side after the last expected write.
   localparam int TAIL_CYCLES = 40;
   localparam logic [CTL_W-1:0] MIXER_BAD_CTL = 4'd15;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
   } mixer_write_type;

   typedef struct packed {
      logic [7:0]       addr;
      logic [CTL_W-1:0] ctl;
      logic             right;
      map_type          map;
   } write_slot_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_cmd;
   logic [CTL_W-1:0]   req_control;
   logic [1:0]         req_side;
   logic [BYTE_W-1:0]  req_level;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [BYTE_W-1:0]  rsp_mixer_addr;
   logic [BYTE_W-1:0]  rsp_mixer_data;
   logic               rsp_last;

   // Shadow of the level table held by the block.
   logic [7:0]   left_level [NUM_CTL];
   logic [7:0]   right_level [NUM_CTL];
   // Register writes still owed by the block, oldest first.
   mixer_write_type pending_writes [$];

   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   int unsigned  mismatches;
   int unsigned  quiet_cycles;

   mixer_level_programmer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_control    (req_control),
      .req_side       (req_side),
      .req_level      (req_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mixer_addr (rsp_mixer_addr),
      .rsp_mixer_data (rsp_mixer_data),
      .rsp_last       (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Level model
   // ---------------------------------------------------------------------

   // Power-up level of one control; only the input switch differs per side.
   function automatic logic [7:0] default_level(input logic [CTL_W-1:0] ctl,
                                                input logic right);
      case (ctl)
         CTL_MASTER, CTL_TREB, CTL_BASS: return 8'd50;
         CTL_PCM, CTL_SYNTH:             return 8'd90;
         CTL_CD:                         return 8'd81;
         CTL_LINE:                       return 8'd65;
         CTL_OSWITCH:                    return 8'd31;
         CTL_ISWITCH:                    return right ? 8'd43 : 8'd85;
         default:                        return 8'd0;
      endcase
   endfunction

   // Fixed order of the 23 register writes and where each takes its level from.
   function automatic write_slot_type write_slot(input int k);
      case (k)
         0:       return '{8'h30, CTL_MASTER,  1'b0, MAP_SCALED};
         1:       return '{8'h31, CTL_MASTER,  1'b1, MAP_SCALED};
         2:       return '{8'h32, CTL_PCM,     1'b0, MAP_THRESH};
         3:       return '{8'h33, CTL_PCM,     1'b1, MAP_THRESH};
         4:       return '{8'h34, CTL_SYNTH,   1'b0, MAP_THRESH};
         5:       return '{8'h35, CTL_SYNTH,   1'b1, MAP_THRESH};
         6:       return '{8'h36, CTL_CD,      1'b0, MAP_THRESH};
         7:       return '{8'h37, CTL_CD,      1'b1, MAP_THRESH};
         8:       return '{8'h38, CTL_LINE,    1'b0, MAP_THRESH};
         9:       return '{8'h39, CTL_LINE,    1'b1, MAP_THRESH};
         10:      return '{8'h3a, CTL_MIC,     1'b0, MAP_THRESH};
         11:      return '{8'h3b, CTL_SPEAKER, 1'b0, MAP_THRESH};
         12:      return '{8'h3f, CTL_IGAIN,   1'b0, MAP_SCALED};
         13:      return '{8'h40, CTL_IGAIN,   1'b1, MAP_SCALED};
         14:      return '{8'h41, CTL_OGAIN,   1'b0, MAP_SCALED};
         15:      return '{8'h42, CTL_OGAIN,   1'b1, MAP_SCALED};
         16:      return '{8'h44, CTL_TREB,    1'b0, MAP_TONE};
         17:      return '{8'h45, CTL_TREB,    1'b1, MAP_TONE};
         18:      return '{8'h46, CTL_BASS,    1'b0, MAP_TONE};
         19:      return '{8'h47, CTL_BASS,    1'b1, MAP_TONE};
         20:      return '{8'h3c, CTL_OSWITCH, 1'b0, MAP_SWITCH};
         21:      return '{8'h3d, CTL_ISWITCH, 1'b0, MAP_SWITCH};
         default: return '{8'h3e, CTL_ISWITCH, 1'b1, MAP_SWITCH};
      endcase
   endfunction

   // Turn a stored level into the byte the mixer register gets.
   function automatic logic [7:0] register_byte(input logic [7:0] v, input map_type map);
      int unsigned c;
      c = (v > LEVEL_MAX) ? LEVEL_MAX : v;
      case (map)
         MAP_SCALED: return 8'(c * 255 / 100);
         MAP_THRESH: return (v == 8'd0) ? 8'd0 : 8'(THRESH_BASE + c);
         MAP_TONE:   return 8'(TONE_BASE + c);
         default:    return v;
      endcase
   endfunction

   function automatic void load_default_levels();
      for (int i = 0; i < NUM_CTL; i++) begin
         left_level[i]  = default_level(CTL_W'(i), 1'b0);
         right_level[i] = default_level(CTL_W'(i), 1'b1);
      end
   endfunction

   // Apply one accepted request to the shadow table and queue the full
   // write run it triggers.
   function automatic void program_levels(input logic cmd, input logic [CTL_W-1:0] ctl,
                                          input logic [1:0] side, input logic [7:0] lvl);
      write_slot_type  slot;
      mixer_write_type w;
      if (cmd == CMD_RESTORE) begin
         load_default_levels();
      end else if (ctl < NUM_CTL) begin
         // Mono controls keep one level on the left, whatever side is asked.
         if (ctl == CTL_MIC || ctl == CTL_SPEAKER || ctl == CTL_OSWITCH) begin
            left_level[ctl] = lvl;
         end else begin
            // Side code three falls through as both sides.
            if (side != SIDE_RIGHT) left_level[ctl] = lvl;
            if (side != SIDE_LEFT)  right_level[ctl] = lvl;
         end
      end
      for (int k = 0; k < NUM_WRITES; k++) begin
         slot   = write_slot(k);
         w.addr = slot.addr;
         w.data = register_byte(slot.right ? right_level[slot.ctl] : left_level[slot.ctl],
                                slot.map);
         w.last = (k == NUM_WRITES - 1);
         pending_writes.push_back(w);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random back-pressure and the in-order compare
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      mixer_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected write transaction addr %0h data %0h last %0b",
                   rsp_mixer_addr, rsp_mixer_data, rsp_last);
            mismatches++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_mixer_addr !== want.addr) begin
               $error("mixer_addr expected %0h got %0h", want.addr, rsp_mixer_addr);
               mismatches++;
            end
            if (rsp_mixer_data !== want.data) begin
               $error("mixer_data expected %0h got %0h", want.data, rsp_mixer_data);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0b got %0b", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // Count cycles with no transaction on either channel; bail out on a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Present one request and hold it until taken. Valid is left high on
   // return so that a back-to-back request only rewrites the payload.
   task automatic send_request(input logic cmd, input logic [CTL_W-1:0] ctl,
                               input logic [1:0] side, input logic [7:0] lvl);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_control <= ctl;
      req_side    <= side;
      req_level   <= lvl;
      do @(posedge clock); while (!req_ready);
      program_levels(cmd, ctl, side, lvl);
   endtask

   // Drop valid and hold off until every owed write has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_writes.size() != 0);
   endtask

   // Level picks that favor the mapping corners: zero, the 100 clamp, full byte.
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'($urandom_range(98, 102));
         2:       return 8'($urandom_range(250, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Power-up table: out-of-range sets leave it alone, so the first runs
   // show the defaults; then a restore with junk fields.
   task automatic test_power_up_table();
      send_request(CMD_SET, 4'd14, SIDE_BOTH, 8'd77);
      send_request(CMD_SET, MIXER_BAD_CTL, 2'd3, 8'd255);
      send_request(CMD_RESTORE, 4'd15, 2'd3, 8'd255);
   endtask

   // One hit on each mapping at its edges, every side code, the mono
   // controls from the wrong side, then restore to undo it all.
   task automatic test_mapping_corners();
      send_request(CMD_SET, CTL_MASTER,  SIDE_BOTH,  8'd0);
      send_request(CMD_SET, CTL_MASTER,  SIDE_LEFT,  8'd100);
      send_request(CMD_SET, CTL_MASTER,  SIDE_RIGHT, 8'd101);
      send_request(CMD_SET, CTL_OGAIN,   2'd3,       8'd255);
      send_request(CMD_SET, CTL_IGAIN,   SIDE_BOTH,  8'd1);
      send_request(CMD_SET, CTL_PCM,     SIDE_BOTH,  8'd0);
      send_request(CMD_SET, CTL_PCM,     SIDE_LEFT,  8'd1);
      send_request(CMD_SET, CTL_SYNTH,   SIDE_RIGHT, 8'd255);
      send_request(CMD_SET, CTL_CD,      SIDE_BOTH,  8'd100);
      send_request(CMD_SET, CTL_LINE,    2'd3,       8'd101);
      send_request(CMD_SET, CTL_TREB,    SIDE_BOTH,  8'd0);
      send_request(CMD_SET, CTL_BASS,    SIDE_LEFT,  8'd255);
      send_request(CMD_SET, CTL_BASS,    SIDE_RIGHT, 8'd99);
      send_request(CMD_SET, CTL_MIC,     SIDE_RIGHT, 8'd170);
      send_request(CMD_SET, CTL_SPEAKER, SIDE_LEFT,  8'd255);
      send_request(CMD_SET, CTL_OSWITCH, 2'd3,       8'd85);
      send_request(CMD_SET, CTL_ISWITCH, SIDE_LEFT,  8'd255);
      send_request(CMD_SET, CTL_ISWITCH, SIDE_RIGHT, 8'd0);
      send_request(CMD_SET, 4'd13,       SIDE_BOTH,  8'd1);
      send_request(CMD_RESTORE, CTL_MASTER, SIDE_BOTH, 8'd0);
   endtask

   // Mostly well-formed sets, with some restores and out-of-range controls.
   task automatic test_random_requests(input int count);
      int unsigned roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            send_request(CMD_RESTORE, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)));
         end else if (roll < 13) begin
            send_request(CMD_SET, 4'($urandom_range(13, 15)), 2'($urandom_range(0, 3)),
                         pick_level());
         end else begin
            send_request(CMD_SET, 4'($urandom_range(0, NUM_CTL - 1)),
                         2'($urandom_range(0, 3)), pick_level());
         end
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_SET;
      req_control   <= CTL_MASTER;
      req_side      <= SIDE_BOTH;
      req_level     <= 8'd0;
      send_idle_pct = 37;
      recv_idle_pct = 46;
      load_default_levels();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_power_up_table();
      test_mapping_corners();
      test_random_requests(110);
      hold_until_drained();

      send_idle_pct = 46;
      recv_idle_pct = 37;
      test_random_requests(110);
      hold_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_requests(110);

      // Let the last run drain, then watch for stray writes.
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else                 $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
